[rtl/core/hssm_pkg.sv]
`default_nettype none
package hssm_pkg;

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_CLK9  = 6'b000010,
    PH_START = 6'b000100,
    PH_WRITE = 6'b001000,
    PH_WAIT  = 6'b010000,
    PH_READ  = 6'b100000
  } phase_e;

  typedef enum logic [2:0] {
    OP_TEMP   = 3'd0,
    OP_HUMID  = 3'd1,
    OP_RD_STS = 3'd2,
    OP_WR_STS = 3'd3,
    OP_SRESET = 3'd4
  } op_e;

  localparam logic [1:0] CFG_HALF    = 2'd0;
  localparam logic [1:0] CFG_POLL    = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT = 2'd2;

  localparam logic [7:0] CRC_POLY  = 8'h31;
  localparam logic [3:0] CLK_COUNT = 4'd9;

  typedef struct packed {
    logic [0:0] req_type;
    logic [2:0] op;
    logic [7:0] status_write_value;
    logic [0:0] data_in;
  } in_t;

  typedef struct packed {
    logic [0:0]  sck;
    logic [0:0]  data_release;
    logic [0:0]  busy_res;
    logic [0:0]  done_res;
    logic [15:0] measured_value;
    logic [7:0]  checksum_byte;
    logic [7:0]  status_byte;
    logic [0:0]  no_ack;
    logic [0:0]  timeout_flag;
    logic [0:0]  crc_error;
  } out_t;

  function automatic logic [7:0] cmd_code(input logic [2:0] op);
    case (op)
      OP_TEMP:   cmd_code = 8'h03;
      OP_HUMID:  cmd_code = 8'h05;
      OP_RD_STS: cmd_code = 8'h07;
      OP_WR_STS: cmd_code = 8'h06;
      OP_SRESET: cmd_code = 8'h1E;
      default:   cmd_code = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic b);
    crc_step = {crc[6:0], 1'b0} ^ ((crc[7] ^ b) ? CRC_POLY : 8'h00);
  endfunction

  function automatic logic [7:0] reverse8(input logic [7:0] v);
    for (int i = 0; i < 8; i++) reverse8[i] = v[7-i];
  endfunction

endpackage
`default_nettype wire

[rtl/core/hssm_if.sv]
`default_nettype none
interface hssm_in_if;
  logic            valid;
  logic            ready;
  hssm_pkg::in_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface hssm_out_if;
  logic            valid;
  logic            ready;
  hssm_pkg::out_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[rtl/core/humidity_sensor_serial_master_top.sv]
// The result of a beat is registered and shown in the cycle after the input beat is taken.
// Throughput: one beat per cycle while the output is not stalled; the bus state machine advances once per beat.
// The output register is refilled in the cycle it is taken, so no bubble forms.
// Reset: asynchronous, active low; the bus goes idle and the registers reset
// to half period 100, poll interval 2000 and timeout 100.
`default_nettype none
module humidity_sensor_serial_master_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  hssm_in_if.sink          in_if,
  hssm_out_if.source       out_if,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  logic [15:0] half_q, poll_q;
  logic [7:0]  tmo_q;

  hssm_pkg::phase_e phase_q, phase_d;
  logic [15:0] tick_q, tick_d;
  logic [3:0]  bit_q, bit_d;
  logic        half_sel_q, half_sel_d;
  logic [7:0]  sr_q, sr_d, crc_q, crc_d, poll_cnt_q, poll_cnt_d, pend_q, pend_d;
  logic [1:0]  bidx_q, bidx_d;
  logic [2:0]  op_q, op_d, err_q, err_d;
  logic [31:0] hold_q, hold_d;
  logic        ovalid_q;
  hssm_pkg::out_t opay_q, opay_d;

  logic        take, start, sck, rel, done, is_meas, last_rd, din;
  logic [15:0] dur;

  assign take        = in_if.valid && in_if.ready;
  assign in_if.ready = !ovalid_q || out_if.ready;
  assign din         = in_if.payload.data_in;

  always_comb begin
    phase_d = phase_q; tick_d = tick_q; bit_d = bit_q; half_sel_d = half_sel_q;
    sr_d = sr_q; crc_d = crc_q; poll_cnt_d = poll_cnt_q; pend_d = pend_q;
    bidx_d = bidx_q; op_d = op_q; err_d = err_q; hold_d = hold_q;
    sck = 1'b0; rel = 1'b1; done = 1'b0; dur = half_q;
    is_meas = 1'b0; last_rd = 1'b0;

    start = in_if.payload.req_type[0] && (phase_q == hssm_pkg::PH_IDLE)
            && (in_if.payload.op <= hssm_pkg::OP_SRESET);
    if (start) begin
      op_d = in_if.payload.op;
      pend_d = in_if.payload.status_write_value;
      err_d = 3'd0; crc_d = 8'd0; bidx_d = 2'd0; tick_d = 16'd0;
      half_sel_d = 1'b0; bit_d = 4'd0;
      phase_d = (in_if.payload.op == hssm_pkg::OP_SRESET) ? hssm_pkg::PH_CLK9
                                                          : hssm_pkg::PH_START;
    end
    is_meas = (op_d <= hssm_pkg::OP_HUMID);
    last_rd = is_meas ? (bidx_d == 2'd2) : (bidx_d == 2'd1);

    if (phase_d != hssm_pkg::PH_IDLE) begin
      case (phase_d)
        hssm_pkg::PH_CLK9: sck = !half_sel_d;
        hssm_pkg::PH_START: begin
          sck = (bit_d[2:0] == 3'd1) || (bit_d[2:0] == 3'd2)
                || (bit_d[2:0] == 3'd5) || (bit_d[2:0] == 3'd6);
          rel = (bit_d[2:0] == 3'd0) || (bit_d[2:0] == 3'd1)
                || (bit_d[2:0] == 3'd6) || (bit_d[2:0] == 3'd7);
        end
        hssm_pkg::PH_WRITE: begin
          if (bit_d < 4'd8) begin
            sck = !half_sel_d; rel = sr_d[7];
          end else begin
            sck = (bit_d == 4'd9);
          end
        end
        hssm_pkg::PH_WAIT: dur = poll_q;
        hssm_pkg::PH_READ: begin
          if (bit_d == 4'd0) begin
            sck = 1'b0;
          end else if (bit_d <= 4'd8) begin
            sck = !half_sel_d;
          end else begin
            sck = (bit_d == 4'd10); rel = last_rd;
          end
        end
        default: ;
      endcase
      if (dur == 16'd0) dur = 16'd1;
      tick_d = tick_d + 16'd1;
      if (tick_d >= dur) begin
        tick_d = 16'd0;
        case (phase_d)
          hssm_pkg::PH_CLK9: begin
            if (!half_sel_d) begin
              half_sel_d = 1'b1;
            end else begin
              half_sel_d = 1'b0; bit_d = bit_d + 4'd1;
              if (bit_d >= hssm_pkg::CLK_COUNT) begin
                phase_d = hssm_pkg::PH_START; bit_d = 4'd0;
              end
            end
          end
          hssm_pkg::PH_START: begin
            bit_d = bit_d + 4'd1;
            if (bit_d >= 4'd7) begin
              phase_d = hssm_pkg::PH_WRITE; sr_d = hssm_pkg::cmd_code(op_d);
              bit_d = 4'd0; half_sel_d = 1'b0;
            end
          end
          hssm_pkg::PH_WRITE: begin
            if (bit_d < 4'd8) begin
              if (!half_sel_d) begin
                half_sel_d = 1'b1;
              end else begin
                crc_d = hssm_pkg::crc_step(crc_d, sr_d[7]);
                sr_d = {sr_d[6:0], 1'b0};
                half_sel_d = 1'b0; bit_d = bit_d + 4'd1;
              end
            end else if (bit_d == 4'd8) begin
              if (din) err_d[0] = 1'b1;
              bit_d = 4'd9;
            end else if (op_d == hssm_pkg::OP_WR_STS && bidx_d == 2'd0) begin
              bidx_d = 2'd1; sr_d = pend_d; bit_d = 4'd0; half_sel_d = 1'b0;
            end else if (is_meas) begin
              phase_d = hssm_pkg::PH_WAIT; poll_cnt_d = 8'd0;
            end else if (op_d == hssm_pkg::OP_RD_STS) begin
              bidx_d = 2'd0; phase_d = hssm_pkg::PH_READ;
              sr_d = 8'd0; bit_d = 4'd0; half_sel_d = 1'b0;
            end else begin
              phase_d = hssm_pkg::PH_IDLE; done = 1'b1;
            end
          end
          hssm_pkg::PH_WAIT: begin
            if (!din) begin
              bidx_d = 2'd0; phase_d = hssm_pkg::PH_READ;
              sr_d = 8'd0; bit_d = 4'd0; half_sel_d = 1'b0;
            end else begin
              if (poll_cnt_d != 8'hFF) poll_cnt_d = poll_cnt_d + 8'd1;
              if (poll_cnt_d >= tmo_q) begin
                err_d[1] = 1'b1; bidx_d = 2'd0; phase_d = hssm_pkg::PH_READ;
                sr_d = 8'd0; bit_d = 4'd0; half_sel_d = 1'b0;
              end
            end
          end
          hssm_pkg::PH_READ: begin
            if (bit_d == 4'd0) begin
              bit_d = 4'd1;
            end else if (bit_d <= 4'd8) begin
              if (!half_sel_d) begin
                sr_d = {sr_d[6:0], din};
                if (!(is_meas && last_rd)) crc_d = hssm_pkg::crc_step(crc_d, din);
                half_sel_d = 1'b1;
              end else begin
                half_sel_d = 1'b0; bit_d = bit_d + 4'd1;
              end
            end else if (bit_d < 4'd11) begin
              bit_d = bit_d + 4'd1;
            end else begin
              if (is_meas) begin
                if (bidx_d == 2'd0) hold_d[15:8] = sr_d;
                else if (bidx_d == 2'd1) hold_d[7:0] = sr_d;
                else begin
                  hold_d[23:16] = sr_d;
                  if (hssm_pkg::reverse8(crc_d) != sr_d) err_d[2] = 1'b1;
                  phase_d = hssm_pkg::PH_IDLE; done = 1'b1;
                end
              end else begin
                if (bidx_d == 2'd0) hold_d[31:24] = sr_d;
                else begin
                  hold_d[23:16] = sr_d;
                  phase_d = hssm_pkg::PH_IDLE; done = 1'b1;
                end
              end
              if (!done) begin
                bidx_d = bidx_d + 2'd1; sr_d = 8'd0; bit_d = 4'd0; half_sel_d = 1'b0;
              end
            end
          end
          default: phase_d = hssm_pkg::PH_IDLE;
        endcase
      end
    end

    opay_d.sck = sck;
    opay_d.data_release = rel;
    opay_d.busy_res = (phase_d != hssm_pkg::PH_IDLE);
    opay_d.done_res = done;
    opay_d.measured_value = hold_d[15:0];
    opay_d.checksum_byte = hold_d[23:16];
    opay_d.status_byte = hold_d[31:24];
    opay_d.no_ack = err_d[0];
    opay_d.timeout_flag = err_d[1];
    opay_d.crc_error = err_d[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= 16'd100; poll_q <= 16'd2000; tmo_q <= 8'd100;
      phase_q <= hssm_pkg::PH_IDLE; tick_q <= '0; bit_q <= '0; half_sel_q <= 1'b0;
      sr_q <= '0; crc_q <= '0; poll_cnt_q <= '0; pend_q <= '0; bidx_q <= '0;
      op_q <= '0; err_q <= '0; hold_q <= '0; ovalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          hssm_pkg::CFG_HALF:    half_q <= cfg_data_i;
          hssm_pkg::CFG_POLL:    poll_q <= cfg_data_i;
          hssm_pkg::CFG_TIMEOUT: tmo_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (take) begin
        phase_q <= phase_d; tick_q <= tick_d; bit_q <= bit_d; half_sel_q <= half_sel_d;
        sr_q <= sr_d; crc_q <= crc_d; poll_cnt_q <= poll_cnt_d; pend_q <= pend_d;
        bidx_q <= bidx_d; op_q <= op_d; err_q <= err_d; hold_q <= hold_d;
        ovalid_q <= 1'b1;
      end else if (out_if.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) opay_q <= opay_d;
  end

  assign out_if.valid   = ovalid_q;
  assign out_if.payload = opay_q;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.payload))
    else $error("stalled result beat changed");
  a_idle_outputs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == hssm_pkg::PH_IDLE |-> bit_q <= 4'd11)
    else $error("bit counter out of range");
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.payload.done_res |-> !out_if.payload.busy_res)
    else $error("done beat while busy");

endmodule
`default_nettype wire

[tb/humidity_sensor_serial_master_top_test.sv]
`timescale 1ns / 1ps
module humidity_sensor_serial_master_top_test;
  import hssm_pkg::*;

  localparam logic [7:0] START_SCK = 8'b01100110;
  localparam logic [7:0] START_REL = 8'b11000011;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_index_i;
  logic [15:0] cfg_data_i;

  hssm_in_if in_ch ();
  hssm_out_if out_ch ();

  humidity_sensor_serial_master_top dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_if(in_ch),
    .out_if(out_ch),
    .cfg_we_i(cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  // Predicted bus master state.
  logic [15:0] half_ticks, poll_ticks;
  logic [7:0] poll_limit;
  phase_e bus_ph;
  logic [15:0] tick_cnt;
  logic [3:0] bit_cnt;
  logic half_sel;
  logic [7:0] shreg, crc_acc, poll_cnt, pend_byte;
  logic [1:0] byte_idx;
  logic [2:0] cur_op, err_flags;
  logic [31:0] held;

  out_t expected_beats[$];
  int errors;
  int n_items;
  int burst_left;
  bit sensor_mute, sensor_slow, sensor_good;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [7:0] command_of(logic [2:0] op);
    case (op)
      OP_TEMP:   return 8'h03;
      OP_HUMID:  return 8'h05;
      OP_RD_STS: return 8'h07;
      OP_WR_STS: return 8'h06;
      OP_SRESET: return 8'h1E;
      default:   return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] bit_reverse(logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[i] = v[7-i];
    return r;
  endfunction

  function automatic void crc_feed(logic b);
    logic fb;
    fb = crc_acc[7] ^ b;
    crc_acc = {crc_acc[6:0], 1'b0} ^ (fb ? 8'h31 : 8'h00);
  endfunction

  function automatic bit measuring();
    return cur_op <= OP_HUMID;
  endfunction

  function automatic bit final_byte();
    return measuring() ? (byte_idx == 2'd2) : (byte_idx == 2'd1);
  endfunction

  function automatic void start_write(logic [7:0] b);
    bus_ph = PH_WRITE;
    shreg = b;
    bit_cnt = 0;
    half_sel = 0;
  endfunction

  function automatic void start_read();
    bus_ph = PH_READ;
    shreg = 0;
    bit_cnt = 0;
    half_sel = 0;
  endfunction

  function automatic bit write_finished();
    if (cur_op == OP_WR_STS && byte_idx == 0) begin
      byte_idx = 1;
      start_write(pend_byte);
      return 0;
    end
    if (measuring()) begin
      bus_ph = PH_WAIT;
      poll_cnt = 0;
      return 0;
    end
    if (cur_op == OP_RD_STS) begin
      byte_idx = 0;
      start_read();
      return 0;
    end
    bus_ph = PH_IDLE;
    return 1;
  endfunction

  function automatic bit read_finished();
    if (measuring()) begin
      if (byte_idx == 0) begin
        held[15:8] = shreg;
      end else if (byte_idx == 1) begin
        held[7:0] = shreg;
      end else begin
        held[23:16] = shreg;
        if (bit_reverse(crc_acc) != shreg) err_flags[2] = 1'b1;
        bus_ph = PH_IDLE;
        return 1;
      end
    end else begin
      if (byte_idx == 0) begin
        held[31:24] = shreg;
      end else begin
        held[23:16] = shreg;
        bus_ph = PH_IDLE;
        return 1;
      end
    end
    byte_idx = byte_idx + 2'd1;
    start_read();
    return 0;
  endfunction

  function automatic bit segment_end(logic din);
    case (bus_ph)
      PH_CLK9: begin
        if (!half_sel) begin
          half_sel = 1;
        end else begin
          half_sel = 0;
          bit_cnt++;
          if (bit_cnt >= 9) begin
            bus_ph = PH_START;
            bit_cnt = 0;
          end
        end
      end
      PH_START: begin
        bit_cnt++;
        if (bit_cnt >= 7) start_write(command_of(cur_op));
      end
      PH_WRITE: begin
        if (bit_cnt < 8) begin
          if (!half_sel) begin
            half_sel = 1;
          end else begin
            crc_feed(shreg[7]);
            shreg = {shreg[6:0], 1'b0};
            half_sel = 0;
            bit_cnt++;
          end
        end else if (bit_cnt == 8) begin
          if (din) err_flags[0] = 1'b1;
          bit_cnt = 9;
        end else begin
          return write_finished();
        end
      end
      PH_WAIT: begin
        if (!din) begin
          byte_idx = 0;
          start_read();
        end else begin
          if (poll_cnt < 255) poll_cnt++;
          if (poll_cnt >= poll_limit) begin
            err_flags[1] = 1'b1;
            byte_idx = 0;
            start_read();
          end
        end
      end
      PH_READ: begin
        if (bit_cnt == 0) begin
          bit_cnt = 1;
        end else if (bit_cnt <= 8) begin
          if (!half_sel) begin
            shreg = {shreg[6:0], din};
            if (!(measuring() && final_byte())) crc_feed(din);
            half_sel = 1;
          end else begin
            half_sel = 0;
            bit_cnt++;
          end
        end else if (bit_cnt < 11) begin
          bit_cnt++;
        end else begin
          return read_finished();
        end
      end
      default: bus_ph = PH_IDLE;
    endcase
    return 0;
  endfunction

  function automatic out_t bus_tick(in_t it);
    out_t o;
    logic sck, rel, done;
    int dur;
    sck = 0;
    rel = 1;
    done = 0;
    if (it.req_type && bus_ph == PH_IDLE && it.op <= OP_SRESET) begin
      cur_op = it.op;
      pend_byte = it.status_write_value;
      err_flags = 0;
      crc_acc = 0;
      byte_idx = 0;
      tick_cnt = 0;
      half_sel = 0;
      bit_cnt = 0;
      bus_ph = (it.op == OP_SRESET) ? PH_CLK9 : PH_START;
    end
    if (bus_ph != PH_IDLE) begin
      dur = half_ticks;
      case (bus_ph)
        PH_CLK9: sck = !half_sel;
        PH_START: begin
          sck = START_SCK[bit_cnt[2:0]];
          rel = START_REL[bit_cnt[2:0]];
        end
        PH_WRITE: begin
          if (bit_cnt < 8) begin
            sck = !half_sel;
            rel = shreg[7];
          end else begin
            sck = (bit_cnt == 9);
          end
        end
        PH_WAIT: dur = poll_ticks;
        PH_READ: begin
          if (bit_cnt >= 1 && bit_cnt <= 8) begin
            sck = !half_sel;
          end else if (bit_cnt > 8) begin
            sck = (bit_cnt == 10);
            rel = final_byte();
          end
        end
        default: ;
      endcase
      if (dur == 0) dur = 1;
      tick_cnt++;
      if (tick_cnt >= dur) begin
        tick_cnt = 0;
        done = segment_end(it.data_in);
      end
    end
    o.sck = sck;
    o.data_release = rel;
    o.busy_res = (bus_ph != PH_IDLE);
    o.done_res = done;
    o.measured_value = held[15:0];
    o.checksum_byte = held[23:16];
    o.status_byte = held[31:24];
    o.no_ack = err_flags[0];
    o.timeout_flag = err_flags[1];
    o.crc_error = err_flags[2];
    return o;
  endfunction

  // The simulated sensor answers from the predicted bus state.
  function automatic logic sensor_data();
    case (bus_ph)
      PH_WRITE: begin
        if (bit_cnt == 8) return sensor_mute ? 1'b1 : ($urandom_range(0, 19) == 0);
        return $urandom_range(0, 1);
      end
      PH_WAIT: return sensor_slow ? 1'b1 : ($urandom_range(0, 2) != 0);
      PH_READ: begin
        if (sensor_good && measuring() && final_byte() && bit_cnt >= 1 && bit_cnt <= 8)
          return crc_acc[bit_cnt-1];
        return $urandom_range(0, 1);
      end
      default: return $urandom_range(0, 1);
    endcase
  endfunction

  task automatic report(string what, int got, int want);
    errors++;
    if (errors <= 40)
      $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
  endtask

  always @(posedge clk_i) begin
    out_t want;
    out_t got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = out_ch.payload;
      if (expected_beats.size() == 0) begin
        report("unexpected beat", 1, 0);
      end else begin
        want = expected_beats.pop_front();
        if (got.sck !== want.sck) report("sck", got.sck, want.sck);
        if (got.data_release !== want.data_release)
          report("data_release", got.data_release, want.data_release);
        if (got.busy_res !== want.busy_res) report("busy_res", got.busy_res, want.busy_res);
        if (got.done_res !== want.done_res) report("done_res", got.done_res, want.done_res);
        if (got.measured_value !== want.measured_value)
          report("measured_value", got.measured_value, want.measured_value);
        if (got.checksum_byte !== want.checksum_byte)
          report("checksum_byte", got.checksum_byte, want.checksum_byte);
        if (got.status_byte !== want.status_byte)
          report("status_byte", got.status_byte, want.status_byte);
        if (got.no_ack !== want.no_ack) report("no_ack", got.no_ack, want.no_ack);
        if (got.timeout_flag !== want.timeout_flag)
          report("timeout_flag", got.timeout_flag, want.timeout_flag);
        if (got.crc_error !== want.crc_error) report("crc_error", got.crc_error, want.crc_error);
      end
    end
  end

  int stall_mode;
  int stall_cyc;
  always @(posedge clk_i) begin
    stall_cyc++;
    if (stall_cyc % 97 == 0) stall_mode = $urandom_range(0, 4);
    case (stall_mode)
      0, 4: out_ch.ready <= 1'b1;
      1: out_ch.ready <= $urandom_range(0, 1);
      2: out_ch.ready <= ($urandom_range(0, 3) == 0);
      default: out_ch.ready <= (stall_cyc % 3 != 0);
    endcase
  end

  task automatic send_tick(in_t it);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 30);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.payload <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    expected_beats.push_back(bus_tick(it));
    n_items++;
  endtask

  task automatic plain_tick(bit noise);
    in_t it;
    it.req_type = noise ? ($urandom_range(0, 7) == 0) : 1'b0;
    it.op = $urandom_range(0, 7);
    it.status_write_value = $urandom;
    it.data_in = sensor_data();
    send_tick(it);
  endtask

  task automatic run_op(logic [2:0] op, logic [7:0] value, bit mute, bit slow, bit good,
                        bit noise);
    in_t it;
    sensor_mute = mute;
    sensor_slow = slow;
    sensor_good = good;
    it.req_type = 1'b1;
    it.op = op;
    it.status_write_value = value;
    it.data_in = sensor_data();
    send_tick(it);
    while (bus_ph != PH_IDLE) plain_tick(noise);
    repeat ($urandom_range(0, 3)) plain_tick(1'b0);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_timing(logic [15:0] half, logic [15:0] poll, logic [7:0] limit);
    logic [15:0] vals[3];
    drain();
    vals = '{half, poll, {8'h00, limit}};
    for (int i = 0; i < 3; i++) begin
      cfg_we_i <= 1'b1;
      cfg_index_i <= (i == 0) ? CFG_HALF : (i == 1) ? CFG_POLL : CFG_TIMEOUT;
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    half_ticks = half;
    poll_ticks = poll;
    poll_limit = limit;
  endtask

  // The reset half period is checked over the first start segments, and the
  // operation is then finished at a short half period.
  task automatic test_reset_timing();
    in_t it;
    sensor_mute = 1'b0;
    sensor_slow = 1'b0;
    sensor_good = 1'b0;
    it.req_type = 1'b1;
    it.op = OP_WR_STS;
    it.status_write_value = 8'hA5;
    it.data_in = sensor_data();
    send_tick(it);
    repeat (250) plain_tick(1'b0);
    set_timing(16'd1, 16'd1, 8'd3);
    while (bus_ph != PH_IDLE) plain_tick(1'b0);
  endtask

  task automatic test_each_operation();
    set_timing(16'd1, 16'd1, 8'd3);
    run_op(OP_TEMP, 8'h00, 0, 0, 1, 0);
    run_op(OP_HUMID, 8'hFF, 0, 0, 0, 0);
    run_op(OP_RD_STS, 8'h00, 0, 0, 0, 0);
    run_op(OP_WR_STS, 8'hFF, 0, 0, 0, 0);
    run_op(OP_WR_STS, 8'h00, 1, 0, 0, 0);
    run_op(OP_SRESET, 8'h5A, 0, 0, 0, 1);
    for (int op = 5; op < 8; op++) run_op(op[2:0], 8'h33, 0, 0, 0, 0);
    run_op(OP_TEMP, 8'h00, 0, 1, 1, 1);
  endtask

  task automatic test_timing_extremes();
    set_timing(16'd0, 16'd0, 8'd0);
    run_op(OP_HUMID, 8'h00, 0, 1, 1, 0);
    set_timing(16'd1, 16'd1, 8'd255);
    run_op(OP_TEMP, 8'h00, 1, 1, 0, 0);
    set_timing(16'hFFFF, 16'hFFFF, 8'd255);
    for (int i = 0; i < 12; i++) plain_tick(1'b0);
  endtask

  task automatic test_random_traffic();
    while (n_items < 1750) begin
      case ($urandom_range(0, 5))
        0: set_timing($urandom_range(0, 2), $urandom_range(0, 3), $urandom_range(0, 2));
        1: set_timing(1, 1, ($urandom_range(0, 1) ? 8'd255 : 8'd1));
        default: set_timing($urandom_range(1, 3), $urandom_range(1, 4), $urandom_range(1, 8));
      endcase
      repeat ($urandom_range(2, 4)) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 10)) plain_tick(1'b0);
        end else begin
          run_op($urandom_range(0, 7) < 7 ? $urandom_range(0, 4) : $urandom_range(5, 7),
                 $urandom, $urandom_range(0, 9) == 0, $urandom_range(0, 7) == 0,
                 $urandom_range(0, 2) != 0, $urandom_range(0, 1));
        end
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_HALF;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
    errors = 0;
    n_items = 0;
    burst_left = 0;
    stall_mode = 0;
    stall_cyc = 0;
    half_ticks = 16'd100;
    poll_ticks = 16'd2000;
    poll_limit = 8'd100;
    bus_ph = PH_IDLE;
    tick_cnt = 0;
    bit_cnt = 0;
    half_sel = 0;
    shreg = 0;
    crc_acc = 0;
    poll_cnt = 0;
    pend_byte = 0;
    byte_idx = 0;
    cur_op = 0;
    err_flags = 0;
    held = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_timing();
    test_each_operation();
    test_timing_extremes();
    test_random_traffic();
    drain();
    if (errors == 0) begin
      $display("humidity_sensor_serial_master_top_test: PASS");
    end else begin
      $display("humidity_sensor_serial_master_top_test: FAIL");
    end
    $finish;
  end

  initial begin
    #15ms;
    $display("humidity_sensor_serial_master_top_test: FAIL");
    $finish;
  end

endmodule
